>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BSFR_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define BSFR_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> rtl/core/bsfr_pkg.sv
package bsfr_pkg;

    typedef logic [1:0] cfg_index_t;

    localparam cfg_index_t CFG_BOUNDARY = 2'd0;
    localparam cfg_index_t CFG_ESCAPE   = 2'd1;
    localparam cfg_index_t CFG_LIMIT    = 2'd2;

    localparam logic [7:0]  BOUNDARY_RST = 8'h7E;
    localparam logic [7:0]  ESCAPE_RST   = 8'h7D;
    localparam logic [6:0]  LIMIT_RST    = 7'd64;

    localparam logic [7:0]  ESC_FLIP  = 8'h20;
    localparam logic [6:0]  CRC_BYTES = 7'd4;
    localparam logic [16:0] MIN_FRAME = 17'd5;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

    typedef enum logic [2:0] {
        ST_WAIT,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_BODY,
        ST_EMIT_RD,
        ST_EMIT_LD
    } bsfr_state_t;

    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/core/byte_stuffed_frame_receiver.sv
// Input: one line byte per cycle while no frame is being read out.
// Readout of a good frame starts after its last CRC byte and moves each payload
// byte in two steps (payload RAM read, then output register load); the load waits while the output is stalled.
// Input is stalled during readout; it reopens while the final byte waits.
// rst_n is asynchronous: control and config reset; output data/last and the RAM are not.
module byte_stuffed_frame_receiver #(
    parameter int BUFFER_BYTES = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [7:0]          m_axis_tdata,   // [7:0] payload_byte
    output logic                m_axis_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  bsfr_pkg::cfg_index_t cfg_index,
    input  logic [7:0]          cfg_data
);

    import bsfr_pkg::*;

    localparam int         AW      = $clog2(BUFFER_BYTES);
    localparam logic [6:0] BUF_LIM = 7'(BUFFER_BYTES);

    bsfr_state_t state_reg, state_next;
    logic [7:0]  boundary_reg, escape_reg;
    logic [6:0]  limit_reg;
    logic        esc_reg, esc_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [6:0]  flen_reg, flen_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [31:0] crc_reg, crc_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_last_reg, out_last_next;
    logic [7:0]  out_data_reg, out_data_next;

    logic        in_fire, out_fire;
    logic        ram_we, ram_re;
    logic [7:0]  ram_rdata;
    logic [7:0]  c;
    logic        proc;
    logic [16:0] len17;
    logic [6:0]  eff_lim;
    logic [6:0]  plen;
    logic [31:0] rcrc_full;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg != ST_EMIT_RD) && (state_reg != ST_EMIT_LD);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    assign eff_lim   = (limit_reg > BUF_LIM) ? BUF_LIM : limit_reg;
    assign plen      = flen_reg - CRC_BYTES;
    assign len17     = {1'b0, len_hi_reg, c} + 17'(CRC_BYTES);
    assign rcrc_full = {rcrc_reg[23:0], c};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boundary_reg <= BOUNDARY_RST;
            escape_reg   <= ESCAPE_RST;
            limit_reg    <= LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BOUNDARY: boundary_reg <= cfg_data;
                CFG_ESCAPE:   escape_reg   <= cfg_data;
                CFG_LIMIT:    limit_reg    <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_WAIT;
            esc_reg       <= 1'b0;
            len_hi_reg    <= '0;
            flen_reg      <= '0;
            cnt_reg       <= '0;
            rcrc_reg      <= '0;
            crc_reg       <= CRC_INIT;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            esc_reg       <= esc_next;
            len_hi_reg    <= len_hi_next;
            flen_reg      <= flen_next;
            cnt_reg       <= cnt_next;
            rcrc_reg      <= rcrc_next;
            crc_reg       <= crc_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        esc_next       = esc_reg;
        len_hi_next    = len_hi_reg;
        flen_next      = flen_reg;
        cnt_next       = cnt_reg;
        rcrc_next      = rcrc_reg;
        crc_next       = crc_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !out_fire;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        proc           = 1'b0;
        c              = esc_reg ? (s_axis_tdata ^ ESC_FLIP) : s_axis_tdata;

        if (in_fire)
        begin
            priority if (s_axis_tdata == boundary_reg)
            begin
                state_next = ST_LEN_HI;
                esc_next   = 1'b0;
                flen_next  = '0;
                cnt_next   = '0;
                rcrc_next  = '0;
                crc_next   = CRC_INIT;
            end
            else if (state_reg == ST_WAIT)
            begin
            end
            else if (esc_reg)
            begin
                esc_next = 1'b0;
                proc     = 1'b1;
            end
            else if (s_axis_tdata == escape_reg)
            begin
                esc_next = 1'b1;
            end
            else
            begin
                proc = 1'b1;
            end
        end

        if (proc)
        begin
            unique case (state_reg)
                ST_LEN_HI:
                begin
                    len_hi_next = c;
                    state_next  = ST_LEN_LO;
                end
                ST_LEN_LO:
                begin
                    flen_next = len17[6:0];
                    if (len17 > {10'd0, eff_lim} || len17 < MIN_FRAME)
                        state_next = ST_WAIT;
                    else
                        state_next = ST_BODY;
                end
                ST_BODY:
                begin
                    cnt_next = cnt_reg + 7'd1;
                    if (cnt_reg < plen)
                    begin
                        ram_we   = 1'b1;
                        crc_next = crc_feed(crc_reg, c);
                    end
                    else
                    begin
                        rcrc_next = rcrc_full;
                        if (cnt_next == flen_reg)
                        begin
                            if ((crc_reg ^ CRC_INIT) == rcrc_full)
                            begin
                                state_next  = ST_EMIT_RD;
                                rd_idx_next = '0;
                            end
                            else
                            begin
                                state_next = ST_WAIT;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        if (state_reg == ST_EMIT_RD)
        begin
            ram_re     = 1'b1;
            state_next = ST_EMIT_LD;
        end
        else if (state_reg == ST_EMIT_LD && (!out_valid_reg || out_fire))
        begin
            out_valid_next = 1'b1;
            out_data_next  = ram_rdata;
            out_last_next  = (7'(rd_idx_reg) + 7'd1 == plen);
            if (7'(rd_idx_reg) + 7'd1 == plen)
            begin
                state_next = ST_WAIT;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + AW'(1);
                state_next  = ST_EMIT_RD;
            end
        end
    end

    bsfr_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_BYTES)
    ) u_store (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(cnt_reg[AW-1:0]),
        .wr_data(c),
        .rd_en  (ram_re),
        .rd_addr(rd_idx_reg),
        .rd_data(ram_rdata)
    );

endmodule

>>> rtl/core/bsfr_ram.sv
module bsfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/core/bsfr_checker.sv
`include "assert_macros.svh"

module bsfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    logic in_fire;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // held transaction on a stalled output
    `BSFR_ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output changed while stalled")

    // input stays closed while a frame is mid readout
    `BSFR_ASSERT_NOW(a_no_in_mid_frame, clk, rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready, "input open during readout")

    // the output does not turn valid directly on an input byte taken while it is idle
    `BSFR_ASSERT_NXT(a_out_latency, clk, rst_n, in_fire && !m_axis_tvalid, !m_axis_tvalid, "output too soon after input")

    // the configuration channel never stalls
    `BSFR_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready, "config channel stalled")

endmodule

bind byte_stuffed_frame_receiver bsfr_checker u_bsfr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
